FILE: design/aes_pkg.sv
// AES-128 engine package: S-box tables, round helper functions, shared types.
// Used by aes_round and the top level; no dependencies.
package aes_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned NumRounds = 10;

  typedef enum logic [2:0] {
    REG_KEY_HIGH     = 3'd0,
    REG_KEY_LOW      = 3'd1,
    REG_IV_HIGH      = 3'd2,
    REG_IV_LOW       = 3'd3,
    REG_DECRYPT_MODE = 3'd4,
    REG_CHAIN_ENABLE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic       decrypt;
    logic       first;   // initial key addition only
    logic       last;    // no (inv)MixColumns
  } round_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits in bits [127-8i -: 8]
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

endpackage

FILE: design/aes_round.sv
// One AES round (forward or inverse), or the initial key addition.
// Depends on aes_pkg. Purely combinational; shared over all rounds.
module aes_round (
  input  logic [127:0]           state_i,
  input  logic [127:0]           rkey_i,
  input  aes_pkg::round_ctl_t    ctl_i,
  output logic [127:0]           state_o
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [127:0] mixed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = byte_of(state_i, i);
    end
    // forward: subbytes then shift rows; inverse: inv shift then inv subbytes
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        if (ctl_i.decrypt) begin
          t[i + 4*((c+i)&3)] = inv_sbox(s[i + 4*c]);
        end else begin
          t[i + 4*c] = sbox(s[i + 4*((c+i)&3)]);
        end
      end
    end
    // decrypt adds the key before inverse mix columns
    if (ctl_i.decrypt) begin
      for (int i = 0; i < 16; i++) begin
        t[i] = t[i] ^ byte_of(rkey_i, i);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al, u, v;
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (ctl_i.decrypt) begin
        // inverse mix via preprocessing then forward mix
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
      end else begin
        u = '0;
        v = '0;
      end
      al = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
      m[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
      m[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
      m[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) begin
      if (ctl_i.last) begin
        mixed[127-8*i -: 8] = ctl_i.decrypt ? t[i] : t[i] ^ byte_of(rkey_i, i);
      end else begin
        mixed[127-8*i -: 8] = ctl_i.decrypt ? m[i] : m[i] ^ byte_of(rkey_i, i);
      end
    end
    state_o = ctl_i.first ? (state_i ^ rkey_i) : mixed;
  end

endmodule

FILE: design/aes128_cbc_ecb_pkcs7_engine.sv
// AES-128 block engine with ECB/CBC chaining and PKCS#7 pad/strip.
// Depends on aes_pkg and aes_round (one shared round unit).
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------------
//  in      | in  | in_valid_i/in_stall_o| data_high/low, byte_count, final_block
//  out     | out | out_valid_o/out_stall_i| out_high/low, valid_bytes, last_out, pad_error
//  cfg     | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// Sequence: after reset or a key write, the idle state stores key 0, then the
// expand state fills the other round keys (one per cycle into the key memory)
// before the next item starts. Each block then passes through the shared round
// unit: load, initial key add, ten rounds; a full final encrypt block adds a pad block.
// Reset: async active low; key memory has no reset and is filled after reset and
// after any key write. The output register holds a result until taken; a waiting
// result stalls the last round, and in_stall_o stays high until the item's last
// result is in the output register.
module aes128_cbc_ecb_pkcs7_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [63:0]  data_high_i,
  input  logic [63:0]  data_low_i,
  input  logic [4:0]   byte_count_i,
  input  logic         final_block_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [63:0]  out_high_o,
  output logic [63:0]  out_low_o,
  output logic [4:0]   valid_bytes_o,
  output logic         last_out_o,
  output logic         pad_error_o
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXPAND, ST_RUN, ST_OUT
  } state_e;

  logic [7:0] rcon_q;
  state_e state_q;
  logic [3:0] rnd_q;
  logic [127:0] key_q, iv_q, chain_q, st_q, cipher_q, ek_q;
  logic decrypt_q, chain_en_q, stale_q;
  logic fin_q, second_q, pad_blk_q;
  logic [127:0] rk_mem [11];
  logic [127:0] rk_q;
  logic [127:0] rnd_out;
  round_ctl_t ctl;
  logic out_free;

  // output register can take a new result this cycle
  assign out_free = !out_valid_o || !out_stall_i;

  // key schedule step, one round key per cycle
  logic [127:0] nk;
  logic [31:0] tw;
  always_comb begin
    tw = {sbox(ek_q[23:16]), sbox(ek_q[15:8]), sbox(ek_q[7:0]), sbox(ek_q[31:24])};
    tw[31:24] = tw[31:24] ^ rcon_q;
    nk[127:96] = ek_q[127:96] ^ tw;
    nk[95:64]  = ek_q[95:64] ^ nk[127:96];
    nk[63:32]  = ek_q[63:32] ^ nk[95:64];
    nk[31:0]   = ek_q[31:0] ^ nk[63:32];
  end

  // round keys: rk_q is registered, so the address selects the key that the next cycle uses
  logic [3:0] rd_addr;
  always_comb begin
    if (state_q == ST_RUN && rnd_q == 4'(NumRounds - 1)) begin
      // hold the last key while the result waits; a pad block restarts at key 0
      rd_addr = (decrypt_q || (out_free && second_q)) ? 4'd0 : 4'(NumRounds);
    end else if (state_q == ST_RUN) begin
      rd_addr = decrypt_q ? 4'(NumRounds) - rnd_q - 4'd2 : rnd_q + 4'd2;
    end else if (state_q == ST_OUT) begin
      rd_addr = decrypt_q ? 4'(NumRounds - 1) : 4'd1;
    end else begin
      rd_addr = decrypt_q ? 4'(NumRounds) : 4'd0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXPAND) begin
      rk_mem[rnd_q + 4'd1] <= nk;
    end else if (state_q == ST_IDLE && stale_q && !cfg_we_i) begin
      rk_mem[0] <= key_q;
    end
    if (rd_addr <= 4'(NumRounds)) begin
      rk_q <= rk_mem[rd_addr];
    end
  end

  assign ctl.decrypt = decrypt_q;
  assign ctl.first = (state_q != ST_RUN);
  assign ctl.last = (rnd_q == 4'(NumRounds - 1));

  aes_round u_round (
    .state_i(st_q), .rkey_i(rk_q), .ctl_i(ctl), .state_o(rnd_out)
  );

  // padded input block
  logic [4:0] n;
  logic [127:0] padded, in_blk;
  always_comb begin
    n = (byte_count_i > 5'd16) ? 5'd16 : byte_count_i;
    in_blk = {data_high_i, data_low_i};
    padded = in_blk;
    if (final_block_i) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= n) padded[127-8*i -: 8] = 8'(5'd16 - n);
      end
    end
  end

  logic [127:0] plain;
  logic [7:0] pb;
  assign plain = chain_en_q ? (rnd_out ^ chain_q) : rnd_out;
  assign pb = plain[7:0];

  logic start_ok;
  assign start_ok = (state_q == ST_IDLE) && !stale_q && !cfg_we_i;
  assign in_stall_o = !start_ok;
  // st_q holds a loaded block whose initial key add happens in the ST_OUT state
  logic started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q <= '0;
      key_q <= '0;
      iv_q <= '0;
      chain_q <= '0;
      decrypt_q <= 1'b0;
      chain_en_q <= 1'b1;
      stale_q <= 1'b1;
      rcon_q <= 8'h1;
      ek_q <= '0;
      out_valid_o <= 1'b0;
      fin_q <= 1'b0;
      second_q <= 1'b0;
      pad_blk_q <= 1'b0;
      started_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KEY_HIGH: begin key_q[127:64] <= cfg_data_i; stale_q <= 1'b1; end
          REG_KEY_LOW:  begin key_q[63:0] <= cfg_data_i; stale_q <= 1'b1; end
          REG_IV_HIGH: begin
            iv_q[127:64] <= cfg_data_i; chain_q <= {cfg_data_i, iv_q[63:0]};
          end
          REG_IV_LOW: begin
            iv_q[63:0] <= cfg_data_i; chain_q <= {iv_q[127:64], cfg_data_i};
          end
          REG_DECRYPT_MODE: decrypt_q <= cfg_data_i[0];
          REG_CHAIN_ENABLE: chain_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (stale_q && !cfg_we_i) begin
            state_q <= ST_EXPAND;
            stale_q <= 1'b0;
            rnd_q <= '0;
            rcon_q <= 8'h1;
            ek_q <= key_q;
          end else if (in_valid_i && start_ok) begin
            fin_q <= final_block_i;
            second_q <= !decrypt_q && final_block_i && (n == 5'd16);
            pad_blk_q <= 1'b0;
            cipher_q <= in_blk;
            st_q <= decrypt_q ? in_blk : (chain_en_q ? padded ^ chain_q : padded);
            started_q <= 1'b0;
            rnd_q <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_EXPAND: begin
          // a key write during expansion leaves stale_q set, so expansion runs again afterwards
          ek_q <= nk;
          rcon_q <= rcon_q[7] ? 8'h1b : {rcon_q[6:0], 1'b0};
          if (rnd_q == 4'(NumRounds - 1)) begin
            state_q <= ST_IDLE;
            rnd_q <= '0;
          end else begin
            rnd_q <= rnd_q + 4'd1;
          end
        end
        ST_OUT: begin
          // initial key add with rk_q holding key 0 (key 10 when decrypting)
          st_q <= rnd_out;
          rnd_q <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (!started_q || rnd_q != 4'(NumRounds - 1)) begin
            st_q <= rnd_out;
            rnd_q <= rnd_q + 4'd1;
            started_q <= 1'b1;
          end
          if (rnd_q == 4'(NumRounds - 1)) begin
            if (out_free) begin
              out_valid_o <= 1'b1;
              pad_error_o <= 1'b0;
              valid_bytes_o <= 5'd16;
              if (decrypt_q) begin
                {out_high_o, out_low_o} <= plain;
                last_out_o <= fin_q;
                if (chain_en_q) chain_q <= cipher_q;
                if (fin_q) begin
                  if (pb == 8'd0 || pb > 8'd16) begin
                    valid_bytes_o <= '0;
                    pad_error_o <= 1'b1;
                  end else begin
                    valid_bytes_o <= 5'(8'd16 - pb);
                  end
                end
              end else begin
                {out_high_o, out_low_o} <= rnd_out;
                last_out_o <= fin_q && !second_q;
                if (chain_en_q) chain_q <= rnd_out;
              end
              if (second_q) begin
                second_q <= 1'b0;
                st_q <= {16{8'h10}} ^ (chain_en_q ? rnd_out : 128'd0);
                rnd_q <= '0;
                state_q <= ST_OUT;
              end else begin
                if (fin_q) chain_q <= iv_q;
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (out_valid_o && !out_stall_i && !(state_q == ST_RUN &&
          rnd_q == 4'(NumRounds - 1))) begin
        out_valid_o <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_pad_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pad_error_o) |-> (valid_bytes_o == 5'd0 && last_out_o))
    else $error("pad error fields");
`endif

endmodule
